### rtl/core/assert_macros.svh
// Assertion macros shared by the quaternion rotator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define QVR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QVR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/qvr_pkg.sv
// Types and constants for the quaternion vector rotator.
`default_nettype none

package qvr_pkg;

	localparam int FRAC_BITS = 28;
	localparam int NAXES     = 3;
	localparam int NTERMS    = 9;

	typedef logic signed [15:0] qcomp_t;
	typedef logic signed [15:0] vcomp_t;
	typedef logic signed [31:0] qprod_t;
	typedef logic signed [33:0] mterm_t;
	typedef logic signed [49:0] vprod_t;
	typedef logic signed [51:0] vsum_t;
	typedef logic signed [23:0] vround_t;
	typedef logic signed [16:0] rot_t;

	localparam mterm_t M_ONE      = 34'sd268435456;
	localparam vsum_t  ROUND_HALF = 52'sd134217728;
	localparam rot_t   ROT_MAX    = 17'sd65535;
	localparam rot_t   ROT_MIN    = 17'h10000;

	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} stage_ld_t;

endpackage

`default_nettype wire

### rtl/core/qvr_matrix.sv
// Stages 1-2: quaternion component products and rotation matrix terms.
`default_nettype none

module qvr_matrix (
	input  wire logic              clk,
	input  qvr_pkg::stage_ld_t     ld,
	input  qvr_pkg::qcomp_t        quat_w,
	input  qvr_pkg::qcomp_t        quat_x,
	input  qvr_pkg::qcomp_t        quat_y,
	input  qvr_pkg::qcomp_t        quat_z,
	input  qvr_pkg::vcomp_t        vec_x,
	input  qvr_pkg::vcomp_t        vec_y,
	input  qvr_pkg::vcomp_t        vec_z,
	output qvr_pkg::mterm_t        m_s2 [qvr_pkg::NTERMS],
	output qvr_pkg::vcomp_t        v_s2 [qvr_pkg::NAXES]
);
	import qvr_pkg::*;

	qprod_t xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	vcomp_t v_s1 [NAXES];
	mterm_t m_c [NTERMS];

	always_ff @(posedge clk) begin
		if (ld.ld_s1) begin
			xx_s1   <= qprod_t'(quat_x) * qprod_t'(quat_x);
			yy_s1   <= qprod_t'(quat_y) * qprod_t'(quat_y);
			zz_s1   <= qprod_t'(quat_z) * qprod_t'(quat_z);
			xy_s1   <= qprod_t'(quat_x) * qprod_t'(quat_y);
			xz_s1   <= qprod_t'(quat_x) * qprod_t'(quat_z);
			yz_s1   <= qprod_t'(quat_y) * qprod_t'(quat_z);
			wx_s1   <= qprod_t'(quat_w) * qprod_t'(quat_x);
			wy_s1   <= qprod_t'(quat_w) * qprod_t'(quat_y);
			wz_s1   <= qprod_t'(quat_w) * qprod_t'(quat_z);
			v_s1[0] <= vec_x;
			v_s1[1] <= vec_y;
			v_s1[2] <= vec_z;
		end
	end

	// row-major, scale 2^28
	always_comb begin
		m_c[0] = M_ONE - ((mterm_t'(yy_s1) + mterm_t'(zz_s1)) <<< 1);
		m_c[1] = (mterm_t'(xy_s1) - mterm_t'(wz_s1)) <<< 1;
		m_c[2] = (mterm_t'(xz_s1) + mterm_t'(wy_s1)) <<< 1;
		m_c[3] = (mterm_t'(xy_s1) + mterm_t'(wz_s1)) <<< 1;
		m_c[4] = M_ONE - ((mterm_t'(xx_s1) + mterm_t'(zz_s1)) <<< 1);
		m_c[5] = (mterm_t'(yz_s1) - mterm_t'(wx_s1)) <<< 1;
		m_c[6] = (mterm_t'(xz_s1) - mterm_t'(wy_s1)) <<< 1;
		m_c[7] = (mterm_t'(yz_s1) + mterm_t'(wx_s1)) <<< 1;
		m_c[8] = M_ONE - ((mterm_t'(xx_s1) + mterm_t'(yy_s1)) <<< 1);
	end

	always_ff @(posedge clk) begin
		if (ld.ld_s2) begin
			m_s2 <= m_c;
			v_s2 <= v_s1;
		end
	end

endmodule

`default_nettype wire

### rtl/core/qvr_matvec.sv
// Stages 3-4: matrix-vector products, row sums, rounding and saturation.
`default_nettype none

module qvr_matvec (
	input  wire logic                       clk,
	input  qvr_pkg::stage_ld_t              ld,
	input  qvr_pkg::mterm_t                 m_s2 [qvr_pkg::NTERMS],
	input  qvr_pkg::vcomp_t                 v_s2 [qvr_pkg::NAXES],
	output qvr_pkg::rot_t                   rot_s4 [qvr_pkg::NAXES],
	output logic                            clip_s4
);
	import qvr_pkg::*;

	vprod_t           p_s3 [NTERMS];
	vsum_t            sum_c [NAXES];
	vround_t          rnd_c [NAXES];
	rot_t             sat_c [NAXES];
	logic [NAXES-1:0] clip_c;

	always_ff @(posedge clk) begin
		if (ld.ld_s3) begin
			for (int r = 0; r < NAXES; r++) begin
				for (int c = 0; c < NAXES; c++) begin
					p_s3[r*NAXES+c] <= vprod_t'(m_s2[r*NAXES+c]) * vprod_t'(v_s2[c]);
				end
			end
		end
	end

	// floor((sum + 2^27) / 2^28), then clamp to 17 bits
	always_comb begin
		for (int r = 0; r < NAXES; r++) begin
			sum_c[r] = vsum_t'(p_s3[r*NAXES]) + vsum_t'(p_s3[r*NAXES+1])
				+ vsum_t'(p_s3[r*NAXES+2]) + ROUND_HALF;
			rnd_c[r] = sum_c[r][51:FRAC_BITS];
			if (rnd_c[r] > vround_t'(ROT_MAX)) begin
				sat_c[r]  = ROT_MAX;
				clip_c[r] = 1'b1;
			end else if (rnd_c[r] < vround_t'(ROT_MIN)) begin
				sat_c[r]  = ROT_MIN;
				clip_c[r] = 1'b1;
			end else begin
				sat_c[r]  = rnd_c[r][16:0];
				clip_c[r] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld.ld_s4) begin
			rot_s4  <= sat_c;
			clip_s4 <= |clip_c;
		end
	end

endmodule

`default_nettype wire

### rtl/core/quaternion_vector_rotate.sv
// Top level: four-stage quaternion vector rotator with valid/stall handshake.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------
//  in      | in_valid  | in_stall  | quat_w quat_x quat_y quat_z vec_x vec_y vec_z
//  out     | out_valid | out_stall | rot_x rot_y rot_z clipped
//
//  One beat per cycle sustained while out_stall is low; an accepted beat passes stages 1 to 4 to out_valid.
//  Stages: component products, matrix terms, 34x16 products, sum/round/saturate.
//  Each stage loads when it is empty or the stage after it moves, so bubbles close up.
//  out_stall holds the output register; in_stall rises only when all four stages are full.
//  Reset clears the stage valid bits only.
`default_nettype none
`include "assert_macros.svh"

module quaternion_vector_rotate (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  qvr_pkg::qcomp_t       quat_w,
	input  qvr_pkg::qcomp_t       quat_x,
	input  qvr_pkg::qcomp_t       quat_y,
	input  qvr_pkg::qcomp_t       quat_z,
	input  qvr_pkg::vcomp_t       vec_x,
	input  qvr_pkg::vcomp_t       vec_y,
	input  qvr_pkg::vcomp_t       vec_z,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output qvr_pkg::rot_t         rot_x,
	output qvr_pkg::rot_t         rot_y,
	output qvr_pkg::rot_t         rot_z,
	output logic                  clipped
);
	import qvr_pkg::*;

	logic      valid_s1, valid_s2, valid_s3, valid_s4;
	logic      rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	stage_ld_t ld;
	mterm_t    m_s2 [NTERMS];
	vcomp_t    v_s2 [NAXES];
	rot_t      rot_s4 [NAXES];
	logic      clip_s4;

	assign rdy_s4 = !valid_s4 || !out_stall;
	assign rdy_s3 = !valid_s3 || rdy_s4;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign rdy_s1 = !valid_s1 || rdy_s2;

	assign ld.ld_s1 = rdy_s1 && in_valid;
	assign ld.ld_s2 = rdy_s2 && valid_s1;
	assign ld.ld_s3 = rdy_s3 && valid_s2;
	assign ld.ld_s4 = rdy_s4 && valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= in_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
		end
	end

	qvr_matrix u_matrix (
		.clk    (clk),
		.ld     (ld),
		.quat_w (quat_w),
		.quat_x (quat_x),
		.quat_y (quat_y),
		.quat_z (quat_z),
		.vec_x  (vec_x),
		.vec_y  (vec_y),
		.vec_z  (vec_z),
		.m_s2   (m_s2),
		.v_s2   (v_s2)
	);

	qvr_matvec u_matvec (
		.clk     (clk),
		.ld      (ld),
		.m_s2    (m_s2),
		.v_s2    (v_s2),
		.rot_s4  (rot_s4),
		.clip_s4 (clip_s4)
	);

	assign in_stall  = !rdy_s1;
	assign out_valid = valid_s4;
	assign rot_x     = rot_s4[0];
	assign rot_y     = rot_s4[1];
	assign rot_z     = rot_s4[2];
	assign clipped   = clip_s4;

	`QVR_ASSERT_NOW(a_clip_on_rail, valid_s4 && clipped, rot_x == ROT_MAX || rot_x == ROT_MIN || rot_y == ROT_MAX || rot_y == ROT_MIN || rot_z == ROT_MAX || rot_z == ROT_MIN, "clipped set with no component on a rail")
	`QVR_ASSERT_NEXT(a_s3_held, valid_s3 && !rdy_s4, valid_s3, "stage 3 beat dropped while blocked")
	`QVR_ASSERT_NEXT(a_enter_s1, in_valid && !in_stall, valid_s1, "accepted beat missing from stage 1")
	`QVR_ASSERT_NOW(a_stall_full, in_stall, valid_s1 && valid_s2 && valid_s3 && valid_s4 && out_stall, "input stalled with room in the pipe")

endmodule

`default_nettype wire
